// ===== rtl/brs_pkg.sv =====
// Package for the lane-parallel Brent root step block.
// Holds working widths, fixed-point constants, item and lane-state types and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package brs_pkg;

   localparam int W = 50;
   typedef logic signed [W-1:0] wide_type;
   typedef logic signed [31:0] q32_type;

   localparam wide_type WMAX = 50'sd140737488355327;
   localparam wide_type ONE = 50'sd65536;
   localparam wide_type THREE_Q = 50'sd49152;

   localparam int QDEPTH = 2;

   typedef enum logic [1:0] {
      AR_MUL = 2'b01,
      AR_DIV = 2'b10
   } arop_type;

   typedef struct packed {
      logic     start;
      arop_type op;
   } ar_req_type;

   typedef struct packed {
      logic        is_start;
      logic        lane_ok;
      logic [3:0]  lane;
      q32_type     start_a;
      q32_type     start_b;
      q32_type     value_a;
      q32_type     value_b;
      logic [30:0] tol;
   } item_type;

   typedef struct packed {
      q32_type     a;
      q32_type     b;
      q32_type     c;
      q32_type     fa;
      q32_type     fb;
      q32_type     fc;
      logic [30:0] tol;
   } lane_state_type;

   function automatic wide_type ext32(input q32_type x);
      ext32 = {{(W-32){x[31]}}, x};
   endfunction

   function automatic wide_type clampw(input wide_type x);
      if (x > WMAX) clampw = WMAX;
      else if (x < -WMAX) clampw = -WMAX;
      else clampw = x;
   endfunction

   function automatic wide_type absw(input wide_type x);
      absw = (x < 0) ? -x : x;
   endfunction

   function automatic q32_type sat32(input wide_type x);
      if (x > 50'sd2147483647) sat32 = 32'sh7FFFFFFF;
      else if (x < -50'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = x[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/brs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module brs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic                                   re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/brs_arith.sv =====
// Shared fixed-point multiply and divide unit: saturating Q16.16 product and quotient.
// Depends on brs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module brs_arith (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire brs_pkg::ar_req_type req,
   input  wire brs_pkg::wide_type   x,
   input  wire brs_pkg::wide_type   y,
   output logic                     done,
   output brs_pkg::wide_type        res
);
   import brs_pkg::*;

   typedef enum logic [3:0] {
      A_IDLE = 4'b0001,
      A_MUL  = 4'b0010,
      A_DIV  = 4'b0100,
      A_FIN  = 4'b1000
   } astate_type;

   astate_type  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] ux_ff, ux_in, uy_ff, uy_in, rem_ff, rem_in;
   logic [95:0] acc_ff, acc_in;
   logic [63:0] num_ff, num_in, quo_ff, quo_in;
   logic        neg_ff, neg_in, mul_ff, mul_in;

   wide_type    xc, yc, ax, ay;
   logic [23:0] pa, pb;
   logic [47:0] prod;
   logic [48:0] trial;
   logic [79:0] mag80;
   logic [47:0] magn;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ux_in = ux_ff;
      uy_in = uy_ff;
      rem_in = rem_ff;
      acc_in = acc_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      mul_in = mul_ff;
      done = 1'b0;
      xc = clampw(x);
      yc = clampw(y);
      ax = absw(xc);
      ay = absw(yc);
      pa = cnt_ff[1] ? ux_ff[47:24] : ux_ff[23:0];
      pb = cnt_ff[0] ? uy_ff[47:24] : uy_ff[23:0];
      prod = 48'(pa) * 48'(pb);
      trial = {rem_ff, num_ff[63]};
      mag80 = mul_ff ? acc_ff[95:16] : 80'(quo_ff);
      magn = (mag80 > 80'(WMAX)) ? WMAX[47:0] : mag80[47:0];
      res = neg_ff ? -wide_type'({2'b00, magn}) : wide_type'({2'b00, magn});
      case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               ux_in = ax[47:0];
               uy_in = ay[47:0];
               neg_in = (xc < 0) ^ (yc < 0);
               cnt_in = '0;
               if (req.op == AR_MUL) begin
                  mul_in = 1'b1;
                  acc_in = '0;
                  state_in = A_MUL;
               end else if (ay == 0) begin
                  // Zero divisor: full scale by the numerator's sign, or zero.
                  mul_in = 1'b0;
                  quo_in = (xc != 0) ? 64'(WMAX[47:0]) : 64'd0;
                  neg_in = xc < 0;
                  state_in = A_FIN;
               end else begin
                  mul_in = 1'b0;
                  num_in = {ax[47:0], 16'd0};
                  rem_in = '0;
                  quo_in = '0;
                  state_in = A_DIV;
               end
            end
         end
         A_MUL: begin
            case (cnt_ff[1:0])
               2'd0:    acc_in = acc_ff + 96'(prod);
               2'd3:    acc_in = acc_ff + (96'(prod) << 48);
               default: acc_in = acc_ff + (96'(prod) << 24);
            endcase
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = A_FIN;
            end
         end
         A_DIV: begin
            if (trial >= {1'b0, uy_ff}) begin
               rem_in = 48'(trial - {1'b0, uy_ff});
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = trial[47:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            num_in = {num_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = A_FIN;
            end
         end
         A_FIN: begin
            done = 1'b1;
            state_in = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      ux_ff <= ux_in;
      uy_ff <= uy_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      mul_ff <= mul_in;
   end
endmodule
`default_nettype wire

// ===== rtl/brs_front.sv =====
// Front end: accepts request words, classifies them, and queues them for the back end.
// Depends on brs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module brs_front #(
   parameter int LANES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_action,
   input  wire logic [3:0]        req_lane,
   input  wire brs_pkg::q32_type  req_start_a,
   input  wire brs_pkg::q32_type  req_start_b,
   input  wire brs_pkg::q32_type  req_value_at_a,
   input  wire brs_pkg::q32_type  req_value_at_b,
   input  wire logic [30:0]       req_tolerance,
   output logic                   q_valid,
   input  wire logic              q_pop,
   output brs_pkg::item_type      q_item
);
   import brs_pkg::*;

   localparam int QAW = $clog2(QDEPTH);

   item_type         slot_ff [QDEPTH];
   logic [QAW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QAW:0]     cnt_ff, cnt_in;
   item_type         entry;
   logic             push_ok, pop_ok;

   always_comb begin
      entry.is_start = (req_action == 1'b0);
      entry.lane_ok = 9'(req_lane) < 9'(LANES);
      entry.lane = req_lane;
      entry.start_a = req_start_a;
      entry.start_b = req_start_b;
      entry.value_a = req_value_at_a;
      entry.value_b = req_value_at_b;
      entry.tol = req_tolerance;
      req_full = cnt_ff == (QAW+1)'(QDEPTH);
      q_valid = cnt_ff != '0;
      q_item = slot_ff[rp_ff];
      push_ok = req_push && !req_full;
      pop_ok = q_pop && q_valid;
      wp_in = push_ok ? wp_ff + QAW'(1) : wp_ff;
      rp_in = pop_ok ? rp_ff + QAW'(1) : rp_ff;
      cnt_in = cnt_ff + (QAW+1)'(push_ok) - (QAW+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) begin
         slot_ff[wp_ff] <= entry;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/brs_back.sv =====
// Back end: sequences one Brent search step per queued word over the shared arithmetic unit.
// Depends on brs_pkg, brs_ram and brs_arith.
`timescale 1ns / 1ps
`default_nettype none
module brs_back #(
   parameter int LANES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire brs_pkg::item_type q_item,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [3:0]             rsp_out_lane,
   output brs_pkg::q32_type       rsp_next_point,
   output logic                   rsp_converged,
   output logic                   rsp_all_done
);
   import brs_pkg::*;

   localparam int AW = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int SW = $bits(lane_state_type);

   typedef enum logic [23:0] {
      S_IDLE   = 24'h000001, S_READ  = 24'h000002, S_SIDE  = 24'h000004,
      S_SWAP   = 24'h000008, S_CHECK = 24'h000010, S_D_T1A = 24'h000020,
      S_M_PA   = 24'h000040, S_D_Q   = 24'h000080, S_D_T1  = 24'h000100,
      S_D_T2   = 24'h000200, S_M1    = 24'h000400, S_M2    = 24'h000800,
      S_M3     = 24'h001000, S_M4    = 24'h002000, S_M5    = 24'h004000,
      S_M6     = 24'h008000, S_SIGN  = 24'h010000, S_G1    = 24'h020000,
      S_G2     = 24'h040000, S_G3    = 24'h080000, S_G4    = 24'h100000,
      S_D_STEP = 24'h200000, S_FIX   = 24'h400000, S_EMIT  = 24'h800000
   } bstate_type;

   typedef struct packed {
      q32_type      a, b, c, fa, fb, fc;
      logic [30:0]  tol;
      logic [30:0]  tact;
      logic signed [32:0] prev;
      wide_type     step, p, q, t1, t2, r1;
      q32_type      pt;
      logic         conv;
   } work_type;

   bstate_type     state_ff, state_in;
   work_type       w_ff, w_in;
   item_type       item_ff, item_in;
   logic           pend_ff, pend_in;
   logic [LANES-1:0] done_ff, done_in;
   logic           rv_ff, rv_in;
   logic [3:0]     rlane_ff;
   q32_type        rpt_ff;
   logic           rconv_ff, rall_ff;

   logic [8:0]     qlane9, ilane9;
   logic [AW-1:0]  raddr, addr;
   logic           ram_we, ram_re;
   lane_state_type ram_wdata, ram_rdata;
   ar_req_type     ar_req;
   wide_type       ar_x, ar_y, ar_res;
   logic           ar_done, op_st, load;
   wide_type       cb, ba, stepc, tactw, sf, lim2;
   logic signed [33:0] d34;
   q32_type        nb;

   brs_ram #(.WIDTH(SW), .DEPTH(LANES)) u_ram (
      .clock(clock), .we(ram_we), .waddr(addr), .wdata(ram_wdata),
      .re(ram_re), .raddr(raddr), .rdata(ram_rdata)
   );

   brs_arith u_arith (
      .clock(clock), .reset(reset), .req(ar_req), .x(ar_x), .y(ar_y),
      .done(ar_done), .res(ar_res)
   );

   always_comb begin
      state_in = state_ff;
      w_in = w_ff;
      item_in = item_ff;
      done_in = done_ff;
      q_pop = 1'b0;
      ram_re = 1'b0;
      ram_we = 1'b0;
      ram_wdata = '{a: w_ff.a, b: w_ff.b, c: w_ff.c, fa: w_ff.fa, fb: w_ff.fb,
                    fc: w_ff.fc, tol: w_ff.tol};
      op_st = 1'b0;
      ar_req.op = AR_MUL;
      ar_x = '0;
      ar_y = '0;
      qlane9 = 9'(q_item.lane);
      ilane9 = 9'(item_ff.lane);
      raddr = qlane9[AW-1:0];
      addr = ilane9[AW-1:0];
      cb = ext32(w_ff.c) - ext32(w_ff.b);
      ba = ext32(w_ff.b) - ext32(w_ff.a);
      d34 = $signed(cb[33:0]) + ((cb < 0) ? 34'sd1 : 34'sd0);
      stepc = wide_type'(d34 >>> 1);
      tactw = wide_type'({1'b0, w_ff.tact});
      lim2 = absw(ar_res) >>> 1;
      if (absw(w_ff.step) < tactw) begin
         sf = (w_ff.step > 0) ? tactw : -tactw;
      end else begin
         sf = w_ff.step;
      end
      nb = sat32(ext32(w_ff.b) + sf);
      load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               ram_re = 1'b1;
               item_in = q_item;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (!item_ff.lane_ok) begin
               w_in.pt = '0;
               w_in.conv = 1'b0;
               state_in = S_EMIT;
            end else if (item_ff.is_start) begin
               w_in.a = item_ff.start_a;
               w_in.b = item_ff.start_b;
               w_in.c = item_ff.start_a;
               w_in.fa = item_ff.value_a;
               w_in.fb = item_ff.value_b;
               w_in.fc = item_ff.value_a;
               w_in.tol = item_ff.tol;
               state_in = S_SIDE;
            end else if (done_ff[addr]) begin
               w_in.pt = ram_rdata.b;
               w_in.conv = 1'b1;
               state_in = S_EMIT;
            end else begin
               w_in.a = ram_rdata.a;
               w_in.b = ram_rdata.b;
               w_in.c = ram_rdata.c;
               w_in.fa = ram_rdata.fa;
               w_in.fb = item_ff.value_b;
               w_in.fc = ram_rdata.fc;
               w_in.tol = ram_rdata.tol;
               state_in = S_SIDE;
            end
         end
         S_SIDE: begin
            if ((w_ff.fb > 0 && w_ff.fc > 0) || (w_ff.fb < 0 && w_ff.fc < 0)) begin
               w_in.c = w_ff.a;
               w_in.fc = w_ff.fa;
            end
            w_in.prev = ba[32:0];
            state_in = S_SWAP;
         end
         S_SWAP: begin
            if (absw(ext32(w_ff.fc)) < absw(ext32(w_ff.fb))) begin
               w_in.a = w_ff.b;
               w_in.b = w_ff.c;
               w_in.c = w_ff.b;
               w_in.fa = w_ff.fb;
               w_in.fb = w_ff.fc;
               w_in.fc = w_ff.fb;
            end
            w_in.tact = 31'd1 + (w_ff.tol >> 1);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            w_in.step = stepc;
            if (absw(stepc) <= tactw || w_ff.fb == 0) begin
               // Converged: the bracket is stored as it stands.
               ram_we = 1'b1;
               done_in[addr] = 1'b1;
               w_in.pt = w_ff.b;
               w_in.conv = 1'b1;
               state_in = S_EMIT;
            end else if (absw(wide_type'(w_ff.prev)) >= tactw &&
                         absw(ext32(w_ff.fa)) > absw(ext32(w_ff.fb))) begin
               state_in = (w_ff.a == w_ff.c) ? S_D_T1A : S_D_Q;
            end else begin
               state_in = S_FIX;
            end
         end
         S_D_T1A: begin
            op_st = 1'b1; ar_req.op = AR_DIV;
            ar_x = ext32(w_ff.fb); ar_y = ext32(w_ff.fa);
            if (ar_done) begin
               w_in.t1 = ext32(sat32(ar_res)); state_in = S_M_PA;
            end
         end
         S_M_PA: begin
            op_st = 1'b1; ar_x = cb; ar_y = w_ff.t1;
            if (ar_done) begin
               w_in.p = ar_res; w_in.q = ONE - w_ff.t1; state_in = S_SIGN;
            end
         end
         S_D_Q: begin
            op_st = 1'b1; ar_req.op = AR_DIV;
            ar_x = ext32(w_ff.fa); ar_y = ext32(w_ff.fc);
            if (ar_done) begin
               w_in.q = ext32(sat32(ar_res)); state_in = S_D_T1;
            end
         end
         S_D_T1: begin
            op_st = 1'b1; ar_req.op = AR_DIV;
            ar_x = ext32(w_ff.fb); ar_y = ext32(w_ff.fc);
            if (ar_done) begin
               w_in.t1 = ext32(sat32(ar_res)); state_in = S_D_T2;
            end
         end
         S_D_T2: begin
            op_st = 1'b1; ar_req.op = AR_DIV;
            ar_x = ext32(w_ff.fb); ar_y = ext32(w_ff.fa);
            if (ar_done) begin
               w_in.t2 = ext32(sat32(ar_res)); state_in = S_M1;
            end
         end
         S_M1: begin
            op_st = 1'b1; ar_x = cb; ar_y = w_ff.q;
            if (ar_done) begin
               w_in.r1 = ar_res; state_in = S_M2;
            end
         end
         S_M2: begin
            op_st = 1'b1; ar_x = w_ff.r1; ar_y = w_ff.q - w_ff.t1;
            if (ar_done) begin
               w_in.r1 = ar_res; state_in = S_M3;
            end
         end
         S_M3: begin
            op_st = 1'b1; ar_x = ba; ar_y = w_ff.t1 - ONE;
            if (ar_done) begin
               w_in.r1 = clampw(w_ff.r1 - ar_res); state_in = S_M4;
            end
         end
         S_M4: begin
            op_st = 1'b1; ar_x = w_ff.t2; ar_y = w_ff.r1;
            if (ar_done) begin
               w_in.p = ar_res; state_in = S_M5;
            end
         end
         S_M5: begin
            op_st = 1'b1; ar_x = w_ff.q - ONE; ar_y = w_ff.t1 - ONE;
            if (ar_done) begin
               w_in.r1 = ar_res; state_in = S_M6;
            end
         end
         S_M6: begin
            op_st = 1'b1; ar_x = w_ff.r1; ar_y = w_ff.t2 - ONE;
            if (ar_done) begin
               w_in.q = ar_res; state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            if (w_ff.p > 0) begin
               w_in.q = -w_ff.q;
            end else begin
               w_in.p = -w_ff.p;
            end
            state_in = S_G1;
         end
         S_G1: begin
            op_st = 1'b1; ar_x = cb; ar_y = w_ff.q;
            if (ar_done) begin
               w_in.r1 = ar_res; state_in = S_G2;
            end
         end
         S_G2: begin
            op_st = 1'b1; ar_x = w_ff.r1; ar_y = THREE_Q;
            if (ar_done) begin
               w_in.r1 = ar_res; state_in = S_G3;
            end
         end
         S_G3: begin
            op_st = 1'b1; ar_x = tactw; ar_y = w_ff.q;
            if (ar_done) begin
               w_in.r1 = clampw(w_ff.r1 - (absw(ar_res) >>> 1)); state_in = S_G4;
            end
         end
         S_G4: begin
            op_st = 1'b1; ar_x = wide_type'(w_ff.prev); ar_y = w_ff.q;
            if (ar_done) begin
               // The interpolated step is taken only when it stays well inside the bracket.
               state_in = (w_ff.p < w_ff.r1 && w_ff.p < lim2) ? S_D_STEP : S_FIX;
            end
         end
         S_D_STEP: begin
            op_st = 1'b1; ar_req.op = AR_DIV; ar_x = w_ff.p; ar_y = w_ff.q;
            if (ar_done) begin
               w_in.step = ar_res; state_in = S_FIX;
            end
         end
         S_FIX: begin
            ram_we = 1'b1;
            ram_wdata.a = w_ff.b;
            ram_wdata.fa = w_ff.fb;
            ram_wdata.b = nb;
            done_in[addr] = 1'b0;
            w_in.pt = nb;
            w_in.conv = 1'b0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rv_ff || rsp_pop) begin
               load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ar_req.start = op_st && !pend_ff;
      pend_in = op_st && !(pend_ff && ar_done);
      rv_in = load || (rv_ff && !rsp_pop);
      rsp_empty = !rv_ff;
      rsp_out_lane = rlane_ff;
      rsp_next_point = rpt_ff;
      rsp_converged = rconv_ff;
      rsp_all_done = rall_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff <= 1'b0;
         done_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
         rv_ff <= rv_in;
      end
      w_ff <= w_in;
      item_ff <= item_in;
      if (load) begin
         rlane_ff <= item_ff.lane;
         rpt_ff <= w_ff.pt;
         rconv_ff <= w_ff.conv;
         rall_ff <= &done_ff;
      end
   end

   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      ar_done |-> pend_ff) else $error("arith result without a pending request");
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CHECK || state_ff == S_FIX))
      else $error("lane state written outside a step end");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !rv_ff) |=> (state_ff == S_IDLE && rv_ff))
      else $error("result not delivered into a free output register");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE && q_valid))
      else $error("queue popped while busy");
endmodule
`default_nettype wire

// ===== rtl/brent_root_step_lanes.sv =====
// Top level of the lane-parallel Brent root step block.
// Depends on brs_pkg, brs_front and brs_back (which holds brs_ram and brs_arith).
//
//   Channel | Handshake          | Word contents
//   --------+--------------------+----------------------------------------------
//   req_    | push / full        | action, lane, bracket, values, tolerance
//   rsp_    | pop / empty        | lane, next point or root, converged, all done
//
// A word's time in the back end depends on its path: ignored words and words whose
// lane has already converged, steps that converge, and the full inverse quadratic and
// secant steps, which run on the single shared arithmetic unit. Each quotient comes
// from a 64-bit restoring divide that makes one bit a cycle, and each product from four
// 24 by 24 partial products. Reset is synchronous and clears the control state and the
// per-lane done flags; the per-lane bracket memory is not cleared. A two-word queue lets
// requests arrive while a step runs, and the output register lets the next step start
// while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module brent_root_step_lanes #(
   parameter int LANES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_action,
   input  wire logic [3:0]        req_lane,
   input  wire brs_pkg::q32_type  req_start_a,
   input  wire brs_pkg::q32_type  req_start_b,
   input  wire brs_pkg::q32_type  req_value_at_a,
   input  wire brs_pkg::q32_type  req_value_at_b,
   input  wire logic [30:0]       req_tolerance,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [3:0]             rsp_out_lane,
   output brs_pkg::q32_type       rsp_next_point,
   output logic                   rsp_converged,
   output logic                   rsp_all_done
);
   import brs_pkg::*;

   // Words move from the front queue to the back sequencer one at a time.
   logic     q_valid, q_pop;
   item_type q_item;

   // The front classifies each word (start or update, lane in range) as it is queued.
   brs_front #(.LANES(LANES)) u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_action(req_action), .req_lane(req_lane),
      .req_start_a(req_start_a), .req_start_b(req_start_b),
      .req_value_at_a(req_value_at_a), .req_value_at_b(req_value_at_b),
      .req_tolerance(req_tolerance),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
   );

   // The back end runs one search step per word and owns the lane state.
   brs_back #(.LANES(LANES)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_lane(rsp_out_lane), .rsp_next_point(rsp_next_point),
      .rsp_converged(rsp_converged), .rsp_all_done(rsp_all_done)
   );
endmodule
`default_nettype wire
